// ===== design/bresenham_line_stepper_top_assert.svh =====
// Assertion macros shared by the line stepper modules.
`ifndef BRESENHAM_LINE_STEPPER_TOP_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BLSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BLSP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BLSP_ASSERT(lbl, prop, msg)
`define BLSP_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/blsp_pkg.sv =====
// Shared types and constants of the Bresenham line stepper.
package blsp_pkg;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	// Per-word control flags carried from the front end to the walker.
	typedef struct packed {
		logic is_start;
		logic x_neg;
		logic y_neg;
		logic last;
	} flags_t;

	localparam int COLOR_BITS = 8;
	localparam logic [COLOR_BITS-1:0] COLOR_RESET = 8'd1;

	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	// Register index (byte address divided by four).
	localparam logic [PADDR_BITS-3:0] REG_COLOR_INDEX = 1'b0;

endpackage

// ===== design/blsp_fifo.sv =====
// Small register-based FIFO used between the stepper stages.
`include "bresenham_line_stepper_top_assert.svh"
module blsp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`BLSP_NEVER(fifo_no_overflow, wr_en && full, "fifo written while full")
	`BLSP_NEVER(fifo_no_underflow, rd_en && empty, "fifo read while empty")
	`BLSP_ASSERT(fifo_count_up, (wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1), "fifo count did not advance on write")

endmodule

// ===== design/blsp_front.sv =====
// Front end: accept commands, classify them and precompute line setup.
module blsp_front #(
	parameter int COORD_BITS = 10
) (
	input  logic                  push,
	output logic                  full,
	input  logic                  command,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic                  q_full,
	output logic                  q_push,
	output blsp_pkg::flags_t      q_flags,
	output logic [COORD_BITS-1:0] q_x,
	output logic [COORD_BITS-1:0] q_y,
	output logic [COORD_BITS-1:0] q_tx,
	output logic [COORD_BITS-1:0] q_ty,
	output logic [COORD_BITS-1:0] q_dx,
	output logic [COORD_BITS:0]   q_ndy,
	output logic [COORD_BITS+1:0] q_err
);

	logic                  x_lt;
	logic                  y_lt;
	logic [COORD_BITS-1:0] dy_abs;

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		x_lt   = (x_start < x_end);
		y_lt   = (y_start < y_end);
		q_dx   = x_lt ? (x_end - x_start) : (x_start - x_end);
		dy_abs = y_lt ? (y_end - y_start) : (y_start - y_end);
		q_ndy  = (COORD_BITS+1)'(0) - {1'b0, dy_abs};
		q_err  = {2'b00, q_dx} + {q_ndy[COORD_BITS], q_ndy};

		q_flags.is_start = (command == blsp_pkg::CMD_START);
		q_flags.x_neg    = !x_lt;
		q_flags.y_neg    = !y_lt;
		q_flags.last     = (x_start == x_end) && (y_start == y_end);

		q_x  = x_start;
		q_y  = y_start;
		q_tx = x_end;
		q_ty = y_end;
	end

endmodule

// ===== design/blsp_back.sv =====
// Back end: hold the line state and walk the error term one pixel per word.
`include "bresenham_line_stepper_top_assert.svh"
module blsp_back #(
	parameter int COORD_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [blsp_pkg::COLOR_BITS-1:0] color,
	input  logic                            q_empty,
	output logic                            q_pop,
	input  blsp_pkg::flags_t                q_flags,
	input  logic [COORD_BITS-1:0]           q_x,
	input  logic [COORD_BITS-1:0]           q_y,
	input  logic [COORD_BITS-1:0]           q_tx,
	input  logic [COORD_BITS-1:0]           q_ty,
	input  logic [COORD_BITS-1:0]           q_dx,
	input  logic [COORD_BITS:0]             q_ndy,
	input  logic [COORD_BITS+1:0]           q_err,
	input  logic                            res_full,
	output logic                            res_push,
	output logic [COORD_BITS-1:0]           res_x,
	output logic [COORD_BITS-1:0]           res_y,
	output logic [blsp_pkg::COLOR_BITS-1:0] res_color,
	output logic                            res_valid,
	output logic                            res_last
);

	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [COORD_BITS-1:0] tgt_x_q;
	logic [COORD_BITS-1:0] tgt_y_q;
	logic [COORD_BITS-1:0] dx_q;
	logic [COORD_BITS:0]   ndy_q;
	logic [COORD_BITS+1:0] err_q;
	logic                  x_neg_q;
	logic                  y_neg_q;
	logic                  active_q;

	logic signed [COORD_BITS+2:0] e2;
	logic signed [COORD_BITS+2:0] ndy_ext;
	logic signed [COORD_BITS+2:0] dx_ext;
	logic signed [COORD_BITS+2:0] err_sum;
	logic                         mv_x;
	logic                         mv_y;
	logic [COORD_BITS-1:0]        x_next;
	logic [COORD_BITS-1:0]        y_next;
	logic                         step_last;

	assign res_push = !q_empty && !res_full;
	assign q_pop    = res_push;

	// One error-term update: compare 2*err against both deltas.
	always_comb begin
		e2      = {err_q, 1'b0};
		ndy_ext = {{2{ndy_q[COORD_BITS]}}, ndy_q};
		dx_ext  = {3'b000, dx_q};
		mv_x    = (e2 >= ndy_ext);
		mv_y    = (e2 <= dx_ext);
		err_sum = {err_q[COORD_BITS+1], err_q}
			+ (mv_x ? ndy_ext : '0)
			+ (mv_y ? dx_ext : '0);
		x_next  = cur_x_q;
		y_next  = cur_y_q;
		if (mv_x) begin
			x_next = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (mv_y) begin
			y_next = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
		step_last = (x_next == tgt_x_q) && (y_next == tgt_y_q);
	end

	always_comb begin
		if (q_flags.is_start) begin
			res_x     = q_x;
			res_y     = q_y;
			res_color = color;
			res_valid = 1'b1;
			res_last  = q_flags.last;
		end else if (active_q) begin
			res_x     = x_next;
			res_y     = y_next;
			res_color = color;
			res_valid = 1'b1;
			res_last  = step_last;
		end else begin
			res_x     = '0;
			res_y     = '0;
			res_color = '0;
			res_valid = 1'b0;
			res_last  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			if (q_flags.is_start) begin
				cur_x_q <= q_x;
				cur_y_q <= q_y;
				tgt_x_q <= q_tx;
				tgt_y_q <= q_ty;
				dx_q    <= q_dx;
				ndy_q   <= q_ndy;
				err_q   <= q_err;
				x_neg_q <= q_flags.x_neg;
				y_neg_q <= q_flags.y_neg;
			end else if (active_q) begin
				cur_x_q <= x_next;
				cur_y_q <= y_next;
				err_q   <= err_sum[COORD_BITS+1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (res_push) begin
			if (q_flags.is_start) begin
				active_q <= !q_flags.last;
			end else if (active_q && step_last) begin
				active_q <= 1'b0;
			end
		end
	end

	`BLSP_ASSERT(back_last_ends_line, (res_push && res_last) |=> !active_q, "line still active after last pixel")
	`BLSP_ASSERT(back_active_not_at_end, active_q |-> !(cur_x_q == tgt_x_q && cur_y_q == tgt_y_q), "active line already sits at its end point")
	`BLSP_ASSERT(back_step_moves, (res_push && !q_flags.is_start && active_q) |=> !($stable(cur_x_q) && $stable(cur_y_q)), "step left the pixel in place")

endmodule

// ===== design/bresenham_line_stepper_top.sv =====
// Top level of the Bresenham line stepper: config port, queues and walker.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  command   | push / full            | command, x_start, y_start, x_end, y_end
//  pixel     | pop / empty            | pixel_x, pixel_y, pixel_color, pixel_valid,
//            |                        | last_pixel
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready (color_index)
//
// One word in, one pixel word out; the walker retires one word per clock while
// a word waits and the pixel queue has room. A pushed word is registered in the
// command queue and then in the pixel queue before it shows on the output.
// Both queues are QUEUE_DEPTH words deep and let either side stall on its own;
// a full pixel queue holds the walker, a full command queue raises full.
// Reset clears the queues, the line-active flag and sets color_index to 1.
module bresenham_line_stepper_top #(
	parameter int COORD_BITS  = 10,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// command channel
	input  logic                            push,
	output logic                            full,
	input  logic                            command,
	input  logic [COORD_BITS-1:0]           x_start,
	input  logic [COORD_BITS-1:0]           y_start,
	input  logic [COORD_BITS-1:0]           x_end,
	input  logic [COORD_BITS-1:0]           y_end,

	// pixel channel
	output logic                            empty,
	input  logic                            pop,
	output logic [COORD_BITS-1:0]           pixel_x,
	output logic [COORD_BITS-1:0]           pixel_y,
	output logic [blsp_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                            pixel_valid,
	output logic                            last_pixel,

	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [blsp_pkg::PADDR_BITS-1:0] paddr,
	input  logic [blsp_pkg::PDATA_BITS-1:0] pwdata,
	output logic [blsp_pkg::PDATA_BITS-1:0] prdata,
	output logic                            pready
);

	localparam int FLAG_BITS = $bits(blsp_pkg::flags_t);
	localparam int CMD_BITS  = FLAG_BITS + 7 * COORD_BITS + 3;
	localparam int RES_BITS  = 2 * COORD_BITS + blsp_pkg::COLOR_BITS + 2;

	// Configuration register: written on the access phase, read back any time.
	logic [blsp_pkg::COLOR_BITS-1:0] color_q;
	logic                            color_sel;

	assign pready    = 1'b1;
	assign color_sel = (paddr[blsp_pkg::PADDR_BITS-1:2] == blsp_pkg::REG_COLOR_INDEX);
	assign prdata    = color_sel
		? {{(blsp_pkg::PDATA_BITS - blsp_pkg::COLOR_BITS){1'b0}}, color_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= blsp_pkg::COLOR_RESET;
		end else if (psel && penable && pwrite && pready && color_sel) begin
			color_q <= pwdata[blsp_pkg::COLOR_BITS-1:0];
		end
	end

	// Front end: classify the word and precompute the setup of a start.
	blsp_pkg::flags_t      f_flags;
	logic                  f_push;
	logic [COORD_BITS-1:0] f_x;
	logic [COORD_BITS-1:0] f_y;
	logic [COORD_BITS-1:0] f_tx;
	logic [COORD_BITS-1:0] f_ty;
	logic [COORD_BITS-1:0] f_dx;
	logic [COORD_BITS:0]   f_ndy;
	logic [COORD_BITS+1:0] f_err;
	logic                  cmd_full;

	blsp_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.push    (push),
		.full    (full),
		.command (command),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.q_full  (cmd_full),
		.q_push  (f_push),
		.q_flags (f_flags),
		.q_x     (f_x),
		.q_y     (f_y),
		.q_tx    (f_tx),
		.q_ty    (f_ty),
		.q_dx    (f_dx),
		.q_ndy   (f_ndy),
		.q_err   (f_err)
	);

	// Command queue between front end and walker.
	logic [CMD_BITS-1:0]   cmd_wr;
	logic [CMD_BITS-1:0]   cmd_rd;
	logic                  cmd_empty;
	logic                  cmd_pop;
	blsp_pkg::flags_t      b_flags;
	logic [COORD_BITS-1:0] b_x;
	logic [COORD_BITS-1:0] b_y;
	logic [COORD_BITS-1:0] b_tx;
	logic [COORD_BITS-1:0] b_ty;
	logic [COORD_BITS-1:0] b_dx;
	logic [COORD_BITS:0]   b_ndy;
	logic [COORD_BITS+1:0] b_err;

	assign cmd_wr = {f_flags, f_x, f_y, f_tx, f_ty, f_dx, f_ndy, f_err};
	assign {b_flags, b_x, b_y, b_tx, b_ty, b_dx, b_ndy, b_err} = cmd_rd;

	blsp_fifo #(
		.WIDTH (CMD_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	// Walker: advance the line state and produce one pixel word per command.
	logic                            res_full;
	logic                            res_push;
	logic [COORD_BITS-1:0]           r_x;
	logic [COORD_BITS-1:0]           r_y;
	logic [blsp_pkg::COLOR_BITS-1:0] r_color;
	logic                            r_valid;
	logic                            r_last;

	blsp_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.color     (color_q),
		.q_empty   (cmd_empty),
		.q_pop     (cmd_pop),
		.q_flags   (b_flags),
		.q_x       (b_x),
		.q_y       (b_y),
		.q_tx      (b_tx),
		.q_ty      (b_ty),
		.q_dx      (b_dx),
		.q_ndy     (b_ndy),
		.q_err     (b_err),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_x     (r_x),
		.res_y     (r_y),
		.res_color (r_color),
		.res_valid (r_valid),
		.res_last  (r_last)
	);

	// Pixel queue: hold finished words until the consumer pops them.
	logic [RES_BITS-1:0] res_wr;
	logic [RES_BITS-1:0] res_rd;

	assign res_wr = {r_valid, r_last, r_color, r_y, r_x};
	assign {pixel_valid, last_pixel, pixel_color, pixel_y, pixel_x} = res_rd;

	blsp_fifo #(
		.WIDTH (RES_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.rd_en   (pop && !empty),
		.rd_data (res_rd),
		.empty   (empty)
	);

endmodule
